// File: rtl/core/fpw_pkg.sv
// shared types, constants and helpers for the framebuffer pixel format writer
// no dependencies
package fpw_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    // width of the bound registers
    localparam int CFG_W = 11;
    localparam int COL_LIM = (MAX_COLUMNS > (2 ** CFG_W) - 1) ? (2 ** CFG_W) - 1 : MAX_COLUMNS;
    localparam int ROW_LIM = (MAX_ROWS > (2 ** CFG_W) - 1) ? (2 ** CFG_W) - 1 : MAX_ROWS;

    localparam int X_W      = $clog2(COL_LIM);
    localparam int Y_W      = $clog2(ROW_LIM);
    localparam int STRIDE_W = CFG_W + 1;
    localparam int LIN_W    = Y_W + STRIDE_W + 1;
    localparam int ACC_W    = LIN_W + 2;
    localparam int ADDR_W   = 22;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int IN_W     = 64;
    localparam int OUT_W    = 72;

    // grayscale weights, unsigned q16
    localparam logic [15:0] GRAY_WR = 16'd13926;
    localparam logic [15:0] GRAY_WG = 16'd46884;
    localparam logic [15:0] GRAY_WB = 16'd4725;

    localparam logic [1:0] PT_MONO   = 2'd0;
    localparam logic [1:0] PT_GRAY   = 2'd1;
    localparam logic [1:0] PT_RGB565 = 2'd2;
    localparam logic [1:0] PT_RGB888 = 2'd3;

    localparam logic [1:0] TM_OPAQUE = 2'd0;
    localparam logic [1:0] TM_CHROMA = 2'd1;
    localparam logic [1:0] TM_ALPHA  = 2'd2;

    localparam logic [2:0] REG_PIXEL_TYPE   = 3'd0;
    localparam logic [2:0] REG_TRANSPARENCY = 3'd1;
    localparam logic [2:0] REG_BIG_ENDIAN   = 3'd2;
    localparam logic [2:0] REG_BUF_COLUMNS  = 3'd3;
    localparam logic [2:0] REG_BUF_ROWS     = 3'd4;
    localparam logic [2:0] REG_IMG_COLUMNS  = 3'd5;

    typedef struct packed {
        logic [1:0]       pixel_type;
        logic [1:0]       transparency_mode;
        logic             big_endian;
        logic [CFG_W-1:0] buffer_columns;
        logic [CFG_W-1:0] buffer_rows;
        logic [CFG_W-1:0] image_columns;
    } cfg_t;

    typedef struct packed {
        logic                reject;
        logic [X_W-1:0]      ux;
        logic [Y_W-1:0]      uy;
        logic [STRIDE_W-1:0] stride;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic [7:0]          alpha;
        logic                on;
        logic [23:0]         prod_r;
        logic [23:0]         prod_g;
        logic [23:0]         prod_b;
    } q_entry_t;

    function automatic logic [CFG_W-1:0] clamp_bound(input logic [CFG_W-1:0] v,
                                                     input logic [CFG_W-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

endpackage

// File: rtl/core/fpw_front.sv
// front end: accepts pixels, checks bounds, classifies and precomputes colour terms
// depends on fpw_pkg
module fpw_front (
    input  fpw_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    input  logic [fpw_pkg::IN_W-1:0]  in_data,
    output fpw_pkg::q_entry_t         entry
);

    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [7:0] red, green, blue, alpha;
    logic [fpw_pkg::CFG_W-1:0] bc, br, ic;
    logic [fpw_pkg::STRIDE_W-1:0] w8_tmp;
    logic chroma, alpha_st, colour;
    logic [8:0] luma_sum;
    logic [7:0] r_adj, g_adj, b_adj;

    always_comb
    begin
        pixel_x  = in_data[15:0];
        pixel_y  = in_data[31:16];
        red      = in_data[39:32];
        green    = in_data[47:40];
        blue     = in_data[55:48];
        alpha    = in_data[63:56];
        bc       = fpw_pkg::clamp_bound(cfg.buffer_columns, fpw_pkg::CFG_W'(fpw_pkg::COL_LIM));
        br       = fpw_pkg::clamp_bound(cfg.buffer_rows, fpw_pkg::CFG_W'(fpw_pkg::ROW_LIM));
        ic       = fpw_pkg::clamp_bound(cfg.image_columns, fpw_pkg::CFG_W'(fpw_pkg::COL_LIM));
        chroma   = (cfg.transparency_mode == fpw_pkg::TM_CHROMA);
        alpha_st = (cfg.transparency_mode == fpw_pkg::TM_ALPHA);
        colour   = (cfg.pixel_type == fpw_pkg::PT_RGB565) ||
                   (cfg.pixel_type == fpw_pkg::PT_RGB888);

        // monochrome row stride rounded up to whole bytes
        w8_tmp = fpw_pkg::STRIDE_W'(ic) + fpw_pkg::STRIDE_W'(7);
        w8_tmp = {w8_tmp[fpw_pkg::STRIDE_W-1:3], 3'b000};

        r_adj = red;
        g_adj = green;
        b_adj = blue;
        if (colour && chroma)
        begin
            if (green == 8'd1 && red == 8'd0 && blue == 8'd0)
            begin
                g_adj = 8'd0;
            end
            if (alpha < 8'h80)
            begin
                r_adj = 8'd0;
                g_adj = (cfg.pixel_type == fpw_pkg::PT_RGB565) ? 8'd4 : 8'd1;
                b_adj = 8'd0;
            end
        end

        luma_sum = 9'(red[7:2]) + 9'(green[7:1]) + 9'(blue[7:2]);

        entry.reject = in_valid &&
                       (pixel_x[15] || pixel_y[15] ||
                        (pixel_x[14:0] >= 15'(bc)) || (pixel_y[14:0] >= 15'(br)));
        entry.ux     = pixel_x[fpw_pkg::X_W-1:0];
        entry.uy     = pixel_y[fpw_pkg::Y_W-1:0];
        entry.stride = (cfg.pixel_type == fpw_pkg::PT_MONO) ? w8_tmp : fpw_pkg::STRIDE_W'(bc);
        entry.red    = r_adj;
        entry.green  = g_adj;
        entry.blue   = b_adj;
        entry.alpha  = alpha;
        entry.on     = luma_sum[7] && !((chroma || alpha_st) && alpha < 8'h80);
        entry.prod_r = 24'(red) * 24'(fpw_pkg::GRAY_WR);
        entry.prod_g = 24'(green) * 24'(fpw_pkg::GRAY_WG);
        entry.prod_b = 24'(blue) * 24'(fpw_pkg::GRAY_WB);
    end

endmodule

// File: rtl/core/fpw_queue.sv
// short request queue between front and back end
// depends on fpw_pkg
module fpw_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fpw_pkg::q_entry_t  push_data,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output fpw_pkg::q_entry_t  pop_data
);

    fpw_pkg::q_entry_t mem [fpw_pkg::QDEPTH];
    logic [fpw_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fpw_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fpw_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full      = (cnt_reg == fpw_pkg::QCNT_W'(fpw_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == fpw_pkg::QPTR_W'(fpw_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == fpw_pkg::QPTR_W'(fpw_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/fpw_back.sv
// back end: linear position multiply, data formatting, byte address and output register
// depends on fpw_pkg
module fpw_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fpw_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  fpw_pkg::q_entry_t             q_data,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fpw_pkg::ADDR_W-1:0]    write_address,
    output logic [31:0]                   write_data,
    output logic [2:0]                    byte_count,
    output logic [7:0]                    bit_mask,
    output logic                          status
);

    typedef struct packed {
        logic                      reject;
        logic                      mono;
        logic                      on;
        logic [fpw_pkg::LIN_W-1:0] lin;
        logic [31:0]               data;
        logic [2:0]                count;
        logic [2:0]                bpp;
    } s1_t;

    s1_t  s1_reg, s1_next;
    logic s1_valid_reg;
    logic out_valid_reg;
    logic adv1, adv2;

    logic [fpw_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [31:0]                data_reg, data_next;
    logic [2:0]                 count_reg, count_next;
    logic [7:0]                 mask_reg, mask_next;
    logic                       status_reg, status_next;

    logic chroma, alpha_st;
    logic [23:0] gray_sum;
    logic [7:0]  gray;
    logic [15:0] w565;
    logic [15:0] w565_ord;
    logic [fpw_pkg::ACC_W-1:0] lin_e, lin_scaled;
    logic [7:0] mono_mask;

    assign adv2  = !out_valid_reg || out_ready;
    assign adv1  = !s1_valid_reg || adv2;
    assign q_pop = q_valid && adv1;

    // stage one: row times stride plus column, colour word
    always_comb
    begin
        chroma   = (cfg.transparency_mode == fpw_pkg::TM_CHROMA);
        alpha_st = (cfg.transparency_mode == fpw_pkg::TM_ALPHA);
        gray_sum = q_data.prod_r + q_data.prod_g + q_data.prod_b;
        gray     = gray_sum[23:16];
        if (chroma)
        begin
            if (gray == 8'd1)
            begin
                gray = 8'd0;
            end
            if (q_data.alpha < 8'h80)
            begin
                gray = 8'd1;
            end
        end
        else if (alpha_st && q_data.alpha != 8'hFF)
        begin
            gray = q_data.alpha;
        end

        w565     = {q_data.red[7:3], q_data.green[7:2], q_data.blue[7:3]};
        w565_ord = cfg.big_endian ? {w565[7:0], w565[15:8]} : w565;

        s1_next.reject = q_data.reject;
        s1_next.mono   = (cfg.pixel_type == fpw_pkg::PT_MONO);
        s1_next.on     = q_data.on;
        s1_next.lin    = fpw_pkg::LIN_W'(q_data.uy) * fpw_pkg::LIN_W'(q_data.stride) +
                         fpw_pkg::LIN_W'(q_data.ux);
        unique case (cfg.pixel_type)
            fpw_pkg::PT_MONO:
            begin
                s1_next.data  = '0;
                s1_next.count = 3'd1;
                s1_next.bpp   = 3'd1;
            end
            fpw_pkg::PT_GRAY:
            begin
                s1_next.data  = {24'd0, gray};
                s1_next.count = 3'd1;
                s1_next.bpp   = 3'd1;
            end
            fpw_pkg::PT_RGB565:
            begin
                s1_next.data  = {8'd0, alpha_st ? q_data.alpha : 8'd0, w565_ord};
                s1_next.count = alpha_st ? 3'd3 : 3'd2;
                s1_next.bpp   = alpha_st ? 3'd3 : 3'd2;
            end
            default:
            begin
                s1_next.data  = {alpha_st ? q_data.alpha : 8'd0,
                                 q_data.blue, q_data.green, q_data.red};
                s1_next.count = alpha_st ? 3'd4 : 3'd3;
                s1_next.bpp   = alpha_st ? 3'd4 : 3'd3;
            end
        endcase
    end

    // stage two: byte address and monochrome bit placement
    always_comb
    begin
        lin_e = fpw_pkg::ACC_W'(s1_reg.lin);
        unique case (s1_reg.bpp)
            3'd2:    lin_scaled = lin_e << 1;
            3'd3:    lin_scaled = lin_e + (lin_e << 1);
            3'd4:    lin_scaled = lin_e << 2;
            default: lin_scaled = lin_e;
        endcase
        mono_mask = 8'h80 >> s1_reg.lin[2:0];

        priority if (s1_reg.reject)
        begin
            addr_next   = '0;
            data_next   = '0;
            count_next  = '0;
            mask_next   = '0;
            status_next = 1'b1;
        end
        else if (s1_reg.mono)
        begin
            addr_next   = fpw_pkg::ADDR_W'(s1_reg.lin >> 3);
            data_next   = s1_reg.on ? {24'd0, mono_mask} : 32'd0;
            count_next  = s1_reg.count;
            mask_next   = mono_mask;
            status_next = 1'b0;
        end
        else
        begin
            addr_next   = fpw_pkg::ADDR_W'(lin_scaled);
            data_next   = s1_reg.data;
            count_next  = s1_reg.count;
            mask_next   = 8'hFF;
            status_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= q_valid;
            end
            if (adv2)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_reg <= s1_next;
        end
        if (adv2 && s1_valid_reg)
        begin
            addr_reg   <= addr_next;
            data_reg   <= data_next;
            count_reg  <= count_next;
            mask_reg   <= mask_next;
            status_reg <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_address = addr_reg;
    assign write_data    = data_reg;
    assign byte_count    = count_reg;
    assign bit_mask      = mask_reg;
    assign status        = status_reg;

endmodule

// File: rtl/core/framebuffer_pixel_format_writer_top.sv
// a pixel request passes through the queue, the stage-one register and the
// output register; each stage takes one pixel per cycle while m_tready is high
// a 2-entry queue between front and back end lets either side stall on its own;
// s_tready drops only while that queue is full
// reset: asynchronous, active low; format registers return to rgb888, opaque,
// little endian, 1024 x 1024 bounds; queue and pipeline are emptied
module framebuffer_pixel_format_writer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [fpw_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pixel_x[15:0], pixel_y[31:16], red[39:32], green[47:40], blue[55:48], alpha[63:56]
    input  logic [fpw_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // write_address[21:0], write_data[53:22], byte_count[56:54], bit_mask[64:57], zero pad
    output logic [fpw_pkg::OUT_W-1:0]     m_tdata,
    // status[0]
    output logic                          m_tuser
);

    fpw_pkg::cfg_t     cfg_reg;
    fpw_pkg::q_entry_t front_entry;
    fpw_pkg::q_entry_t q_head;
    logic q_full, q_not_empty, q_pop;
    logic [fpw_pkg::ADDR_W-1:0] write_address;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
    logic [7:0]  bit_mask;
    logic        status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_type        <= fpw_pkg::PT_RGB888;
            cfg_reg.transparency_mode <= fpw_pkg::TM_OPAQUE;
            cfg_reg.big_endian        <= 1'b0;
            cfg_reg.buffer_columns    <= fpw_pkg::CFG_W'(1024);
            cfg_reg.buffer_rows       <= fpw_pkg::CFG_W'(1024);
            cfg_reg.image_columns     <= fpw_pkg::CFG_W'(1024);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fpw_pkg::REG_PIXEL_TYPE:   cfg_reg.pixel_type        <= cfg_data[1:0];
                fpw_pkg::REG_TRANSPARENCY: cfg_reg.transparency_mode <= cfg_data[1:0];
                fpw_pkg::REG_BIG_ENDIAN:   cfg_reg.big_endian        <= cfg_data[0];
                fpw_pkg::REG_BUF_COLUMNS:  cfg_reg.buffer_columns    <= cfg_data;
                fpw_pkg::REG_BUF_ROWS:     cfg_reg.buffer_rows       <= cfg_data;
                fpw_pkg::REG_IMG_COLUMNS:  cfg_reg.image_columns     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    fpw_front u_front (
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .entry    (front_entry)
    );

    assign s_tready = !q_full;

    fpw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_head)
    );

    fpw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_not_empty),
        .q_data        (q_head),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .write_address (write_address),
        .write_data    (write_data),
        .byte_count    (byte_count),
        .bit_mask      (bit_mask),
        .status        (status)
    );

    assign m_tdata = {7'd0, bit_mask, byte_count, write_data, write_address};
    assign m_tuser = status;

endmodule
